### design/cbba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbba_pkg: shared types and constants
// Block count, field widths, request/response structs, codes and FSM states
// for the contiguous bitmap block allocator.
// ----------------------------------------------------------------------------
package cbba_pkg;

   localparam int NUM_BLOCKS = 128;
   localparam int BLK_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = BLK_W + 1;
   localparam int FIELD_W    = 7;

   localparam logic [CNT_W-1:0] NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_RESIZE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [FIELD_W-1:0] start_req;
      logic [FIELD_W-1:0] old_length;
      logic [FIELD_W-1:0] length;
   } cbba_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] run_start;
      logic               moved;
   } cbba_rsp_type;

   typedef struct packed {
      logic [BLK_W-1:0] addr;
      logic             we;
      logic             wdata;
   } cbba_ram_req_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_SCAN,
      S_MARK,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

### design/cbba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbba_ram: generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module cbba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     we,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

### design/cbba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbba_ctrl: allocator sequencer
// Clears the map, then decodes requests, checks growth ranges, scans first-fit
// one block a cycle, marks runs and registers the response.
// ----------------------------------------------------------------------------
module cbba_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire cbba_pkg::cbba_req_type    req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output cbba_pkg::cbba_rsp_type         rsp_payload,
   output cbba_pkg::cbba_ram_req_type     ram_req,
   input  wire logic                      ram_rdata
);

   import cbba_pkg::*;

   state_type        state_ff, state_in;
   cbba_req_type     req_ff, req_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [BLK_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [CNT_W-1:0] need_ff, need_in;
   logic [BLK_W-1:0] mark_addr_ff, mark_addr_in;
   logic [CNT_W-1:0] mark_cnt_ff, mark_cnt_in;
   logic             mark_val_ff, mark_val_in;
   logic             second_ff, second_in;
   logic [BLK_W-1:0] where_ff, where_in;
   logic [1:0]       status_ff, status_in;
   logic [BLK_W-1:0] res_ff, res_in;
   logic             moved_ff, moved_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cbba_rsp_type     rsp_ff, rsp_in;

   logic [CNT_W-1:0] start_x, len_x, old_x, sum_len, sum_old, run_nx;
   logic [BLK_W-1:0] where_calc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_vld_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      rd_idx_ff    <= rd_idx_in;
      run_ff       <= run_in;
      need_ff      <= need_in;
      mark_addr_ff <= mark_addr_in;
      mark_cnt_ff  <= mark_cnt_in;
      mark_val_ff  <= mark_val_in;
      where_ff     <= where_in;
      status_ff    <= status_in;
      res_ff       <= res_in;
      moved_ff     <= moved_in;
      rsp_ff       <= rsp_in;
   end

   assign start_x    = CNT_W'(req_ff.start_req);
   assign len_x      = CNT_W'(req_ff.length);
   assign old_x      = CNT_W'(req_ff.old_length);
   assign sum_len    = start_x + len_x;
   assign sum_old    = start_x + old_x;
   assign run_nx     = ram_rdata ? '0 : run_ff + CNT_W'(1);
   assign where_calc = BLK_W'({1'b0, rd_idx_ff} + CNT_W'(1) - need_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      run_in       = run_ff;
      need_in      = need_ff;
      mark_addr_in = mark_addr_ff;
      mark_cnt_in  = mark_cnt_ff;
      mark_val_in  = mark_val_ff;
      second_in    = second_ff;
      where_in     = where_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      moved_in     = moved_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_req      = '{addr: idx_ff[BLK_W-1:0], we: 1'b0, wdata: 1'b0};
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.wdata = (idx_ff == '0);
            idx_in        = idx_ff + CNT_W'(1);
            if (idx_ff == NUM_BLOCKS_C - CNT_W'(1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = ST_OK;
            res_in    = '0;
            moved_in  = 1'b0;
            second_in = 1'b0;
            idx_in    = '0;
            run_in    = '0;
            need_in   = len_x;
            state_in  = S_DONE;
            case (req_ff.req_type)
               OP_ALLOC: begin
                  if (len_x != '0) begin
                     state_in = S_SCAN;
                  end
               end
               OP_FREE: begin
                  if (sum_len > NUM_BLOCKS_C) begin
                     status_in = ST_BAD;
                  end else begin
                     res_in       = req_ff.start_req;
                     mark_addr_in = req_ff.start_req;
                     mark_cnt_in  = len_x;
                     mark_val_in  = 1'b0;
                     state_in     = S_MARK;
                  end
               end
               OP_RESIZE: begin
                  if (sum_old > NUM_BLOCKS_C) begin
                     status_in = ST_BAD;
                  end else if (len_x <= old_x) begin
                     res_in       = req_ff.start_req;
                     mark_addr_in = sum_len[BLK_W-1:0];
                     mark_cnt_in  = old_x - len_x;
                     mark_val_in  = 1'b0;
                     state_in     = S_MARK;
                  end else if (sum_len > NUM_BLOCKS_C) begin
                     state_in = S_SCAN;
                  end else begin
                     idx_in   = sum_old;
                     need_in  = len_x - old_x;
                     state_in = S_CHECK;
                  end
               end
               default: begin
                  status_in = ST_BAD;
               end
            endcase
         end

         S_CHECK: begin
            if (idx_ff < sum_len) begin
               idx_in    = idx_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[BLK_W-1:0];
            end
            if (rd_vld_ff) begin
               run_in = run_nx;
               if (ram_rdata) begin
                  idx_in    = '0;
                  run_in    = '0;
                  need_in   = len_x;
                  rd_vld_in = 1'b0;
                  state_in  = S_SCAN;
               end else if (run_nx == need_ff) begin
                  res_in       = req_ff.start_req;
                  mark_addr_in = sum_old[BLK_W-1:0];
                  mark_cnt_in  = need_ff;
                  mark_val_in  = 1'b1;
                  rd_vld_in    = 1'b0;
                  state_in     = S_MARK;
               end
            end
         end

         S_SCAN: begin
            if (idx_ff < NUM_BLOCKS_C) begin
               idx_in    = idx_ff + CNT_W'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff[BLK_W-1:0];
            end
            if (rd_vld_ff) begin
               run_in = run_nx;
               if (run_nx == need_ff) begin
                  res_in    = where_calc;
                  rd_vld_in = 1'b0;
                  state_in  = S_MARK;
                  if (req_ff.req_type == OP_RESIZE) begin
                     moved_in     = 1'b1;
                     where_in     = where_calc;
                     second_in    = 1'b1;
                     mark_addr_in = req_ff.start_req;
                     mark_cnt_in  = old_x;
                     mark_val_in  = 1'b0;
                  end else begin
                     mark_addr_in = where_calc;
                     mark_cnt_in  = need_ff;
                     mark_val_in  = 1'b1;
                  end
               end else if (rd_idx_ff == BLK_W'(NUM_BLOCKS - 1)) begin
                  status_in = ST_NOSPACE;
                  rd_vld_in = 1'b0;
                  state_in  = S_DONE;
               end
            end
         end

         S_MARK: begin
            ram_req.addr = mark_addr_ff;
            if (mark_cnt_ff == '0) begin
               if (second_ff) begin
                  second_in    = 1'b0;
                  mark_addr_in = where_ff;
                  mark_cnt_in  = len_x;
                  mark_val_in  = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               ram_req.we    = 1'b1;
               ram_req.wdata = mark_val_ff;
               mark_addr_in  = mark_addr_ff + BLK_W'(1);
               mark_cnt_in   = mark_cnt_ff - CNT_W'(1);
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.run_start = (status_ff == ST_OK) ? FIELD_W'(res_ff) : '0;
               rsp_in.moved = (status_ff == ST_OK) ? moved_ff : 1'b0;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_write_only_clear_mark: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (state_ff == S_CLEAR || state_ff == S_MARK))
      else $error("map write outside clear or mark");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.run_start == '0 && !rsp_ff.moved)
      else $error("failed response carries a block or move");

   a_moved_resize: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && moved_ff && status_ff == ST_OK |-> req_ff.req_type == OP_RESIZE)
      else $error("move reported for non-resize request");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE && !second_ff)
      else $error("request taken while busy");

   a_second_mark_only_move: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> moved_ff && state_ff == S_MARK)
      else $error("pending relocation mark without a move");

endmodule
`default_nettype wire

### design/contiguous_bitmap_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_bitmap_block_allocator: first-fit contiguous block allocator
// Requests enter on req_valid/req_ready with a packed request struct
// (allocate, free run, resize run); one response per request leaves on
// rsp_valid/rsp_ready with status, start block and moved flag.
// The used/free map sits in a one-bit-wide RAM, one entry per block.
// After decode, a free or shrink writes one block per cycle; a grow-in-place
// check reads one block per cycle; a first-fit scan reads one block per
// cycle; a mark then writes one block per cycle, a relocation clearing the
// old run first. One request is in work at a time; the single RAM port
// sets the rate.
// After reset a clearing pass writes every map entry (block 0 used, the rest
// free); req_ready stays low until it ends.
// A finished response waits in the output register while the next request is
// accepted; a stalled receiver holds the block only when a second response is
// ready to be registered.
// ----------------------------------------------------------------------------
module contiguous_bitmap_block_allocator (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire cbba_pkg::cbba_req_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output cbba_pkg::cbba_rsp_type      rsp_payload
);

   import cbba_pkg::*;

   cbba_ram_req_type ram_req;
   logic             ram_rdata;

   cbba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata)
   );

   cbba_ram #(
      .WIDTH (1),
      .DEPTH (NUM_BLOCKS)
   ) u_map_ram (
      .clock (clock),
      .addr  (ram_req.addr),
      .we    (ram_req.we),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

endmodule
`default_nettype wire

### verif/cbba_allocation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbba_allocation_checker: response checker for the block allocator
// Watches the request and response channels, keeps its own copy of the
// used/free block map, predicts the response of every accepted request and
// compares each returned response field by field against the oldest one.
// ----------------------------------------------------------------------------
module cbba_allocation_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire cbba_pkg::cbba_req_type req_payload,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire cbba_pkg::cbba_rsp_type rsp_payload,
   output int                          fail_count,
   output int                          pending
);
   import cbba_pkg::*;

   logic [NUM_BLOCKS-1:0] used_map;
   cbba_rsp_type          expected_rsp_q[$];
   int                    mismatches;

   function automatic void mark_run(input int first, input int len, input logic v);
      for (int b = first; b < first + len && b < NUM_BLOCKS; b++) begin
         used_map[b] = v;
      end
   endfunction

   function automatic bit run_is_free(input int first, input int len);
      if (first + len > NUM_BLOCKS) begin
         return 1'b0;
      end
      for (int b = first; b < first + len; b++) begin
         if (used_map[b]) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit find_first_fit(input int len, output int where);
      int run;
      run   = 0;
      where = 0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         run = used_map[b] ? 0 : run + 1;
         if (run == len) begin
            where = b + 1 - len;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic cbba_rsp_type predict_allocation(input cbba_req_type r);
      cbba_rsp_type rsp;
      int           first;
      int           old_len;
      int           new_len;
      int           where;
      rsp     = '0;
      first   = r.start_req;
      old_len = r.old_length;
      new_len = r.length;
      case (r.req_type)
         OP_ALLOC: begin
            if (new_len != 0) begin
               if (find_first_fit(new_len, where)) begin
                  mark_run(where, new_len, 1'b1);
                  rsp.run_start = FIELD_W'(where);
               end else begin
                  rsp.status = ST_NOSPACE;
               end
            end
         end
         OP_FREE: begin
            if (first + new_len > NUM_BLOCKS) begin
               rsp.status = ST_BAD;
            end else begin
               mark_run(first, new_len, 1'b0);
               rsp.run_start = FIELD_W'(first);
            end
         end
         OP_RESIZE: begin
            if (first + old_len > NUM_BLOCKS) begin
               rsp.status = ST_BAD;
            end else if (new_len < old_len) begin
               mark_run(first + new_len, old_len - new_len, 1'b0);
               rsp.run_start = FIELD_W'(first);
            end else if (new_len == old_len) begin
               rsp.run_start = FIELD_W'(first);
            end else if (run_is_free(first + old_len, new_len - old_len)) begin
               mark_run(first + old_len, new_len - old_len, 1'b1);
               rsp.run_start = FIELD_W'(first);
            end else if (find_first_fit(new_len, where)) begin
               // relocate: release the old run, then claim the new one
               mark_run(first, old_len, 1'b0);
               mark_run(where, new_len, 1'b1);
               rsp.run_start = FIELD_W'(where);
               rsp.moved     = 1'b1;
            end else begin
               rsp.status = ST_NOSPACE;
            end
         end
         default: begin
            rsp.status = ST_BAD;
         end
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      cbba_rsp_type exp_rsp;
      if (reset) begin
         used_map    = '0;
         used_map[0] = 1'b1;
         expected_rsp_q.delete();
         mismatches  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response transfer: status %0d run_start %0d moved %0d",
                      rsp_payload.status, rsp_payload.run_start, rsp_payload.moved);
               mismatches++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_payload.status !== exp_rsp.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         exp_rsp.status, rsp_payload.status);
                  mismatches++;
               end
               if (rsp_payload.run_start !== exp_rsp.run_start) begin
                  $error("run_start mismatch: expected %0d, actual %0d",
                         exp_rsp.run_start, rsp_payload.run_start);
                  mismatches++;
               end
               if (rsp_payload.moved !== exp_rsp.moved) begin
                  $error("moved mismatch: expected %0d, actual %0d",
                         exp_rsp.moved, rsp_payload.moved);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            exp_rsp        = predict_allocation(req_payload);
            expected_rsp_q = {expected_rsp_q, exp_rsp};
         end
      end
      fail_count <= mismatches;
      pending    <= expected_rsp_q.size();
   end

endmodule

### verif/tb_contiguous_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_bitmap_block_allocator: allocator testbench
// Drives directed allocate, free and resize requests covering the corner
// cases, then random request mixes under three idling profiles and one long
// response stall; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_contiguous_bitmap_block_allocator;
   import cbba_pkg::*;

   localparam logic [1:0] OP_UNDEFINED     = 2'd3;
   localparam int         RANDOM_ITEMS     = 900;
   localparam int         LONG_HOLD_CYCLES = 400;
   localparam int         DRAIN_CYCLES     = 300;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   cbba_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   cbba_rsp_type rsp_payload;

   int fail_count;
   int pending;
   int tx_idle_pct  = 13;
   int rx_idle_pct  = 56;
   bit hold_request = 1'b0;

   contiguous_bitmap_block_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   cbba_allocation_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[contiguous_bitmap_block_allocator] ERROR");
      $finish;
   end

   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic cbba_req_type make_request(input logic [1:0] op, input int first,
                                                 input int old_len, input int new_len);
      cbba_req_type r;
      r.req_type   = op;
      r.start_req  = FIELD_W'(first);
      r.old_length = FIELD_W'(old_len);
      r.length     = FIELD_W'(new_len);
      return r;
   endfunction

   function automatic cbba_req_type random_request();
      cbba_req_type r;
      int           pick;
      pick         = $urandom_range(99);
      r.start_req  = FIELD_W'($urandom_range(127));
      r.old_length = FIELD_W'($urandom_range(127));
      r.length     = FIELD_W'($urandom_range(127));
      if (pick < 45) begin
         r.req_type = OP_ALLOC;
         if ($urandom_range(9) != 0) begin
            r.length = FIELD_W'($urandom_range(16));
         end
      end else if (pick < 75) begin
         r.req_type = OP_FREE;
         if ($urandom_range(9) != 0) begin
            r.length = FIELD_W'($urandom_range(1, 24));
         end
      end else if (pick < 97) begin
         r.req_type = OP_RESIZE;
         if ($urandom_range(4) != 0) begin
            r.old_length = FIELD_W'($urandom_range(16));
            r.length     = FIELD_W'($urandom_range(24));
         end
      end else begin
         r.req_type = OP_UNDEFINED;
      end
      return r;
   endfunction

   task automatic send_request(input cbba_req_type r);
      req_payload <= r;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(OP_ALLOC, 0, 0, 0));
      send_request(make_request(OP_ALLOC, 0, 0, 127));
      send_request(make_request(OP_ALLOC, 0, 0, 1));
      send_request(make_request(OP_FREE, 127, 0, 2));
      send_request(make_request(OP_FREE, 0, 0, 0));
      send_request(make_request(OP_FREE, 0, 0, 1));
      send_request(make_request(OP_ALLOC, 0, 0, 1));
      send_request(make_request(OP_FREE, 1, 0, 127));
      send_request(make_request(OP_ALLOC, 0, 0, 10));
      send_request(make_request(OP_ALLOC, 0, 0, 5));
      send_request(make_request(OP_RESIZE, 1, 10, 10));
      send_request(make_request(OP_RESIZE, 1, 10, 4));
      send_request(make_request(OP_RESIZE, 1, 4, 10));
      send_request(make_request(OP_RESIZE, 1, 10, 20));
      send_request(make_request(OP_RESIZE, 120, 8, 0));
      send_request(make_request(OP_RESIZE, 121, 7, 127));
      send_request(make_request(OP_RESIZE, 100, 28, 30));
      send_request(make_request(OP_RESIZE, 127, 2, 1));
      send_request(make_request(OP_RESIZE, 100, 127, 0));
      send_request(make_request(OP_UNDEFINED, 127, 127, 127));
      send_request(make_request(OP_ALLOC, 127, 127, 127));
      send_request(make_request(OP_FREE, 0, 0, 127));
      send_request(make_request(OP_FREE, 127, 0, 1));
      send_request(make_request(OP_ALLOC, 0, 0, 127));
      send_request(make_request(OP_FREE, 0, 0, 127));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            tx_idle_pct = 56;
            rx_idle_pct = 13;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct  = 0;
            rx_idle_pct  = 0;
            hold_request = 1'b1;
         end
         send_request(random_request());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[contiguous_bitmap_block_allocator] OK");
      end else begin
         $display("[contiguous_bitmap_block_allocator] ERROR");
      end
      $finish;
   end

endmodule
